FILE: src/sabw_pkg.sv
// shared constants, types and helpers for the scaled alpha blit walker
`default_nettype none
package sabw_pkg;

    localparam int SCREEN_W     = 1280;
    localparam int SCREEN_H     = 720;
    localparam int FIELD_WIDTH  = 1280;
    localparam int FIELD_HEIGHT = 720;

    // register indexes
    localparam logic [2:0] REG_DEST_X   = 3'd0;
    localparam logic [2:0] REG_DEST_Y   = 3'd1;
    localparam logic [2:0] REG_DEST_W   = 3'd2;
    localparam logic [2:0] REG_DEST_H   = 3'd3;
    localparam logic [2:0] REG_SRC_W    = 3'd4;
    localparam logic [2:0] REG_SRC_H    = 3'd5;
    localparam logic [2:0] REG_BLEND    = 3'd6;

    // divider widths: numerator up to 14 x 11 bits, divisor up to 15 bits
    localparam int NUM_W = 26;
    localparam int DEN_W = 15;
    localparam int CNT_W = 5;

    // alpha codes
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // geometry handed from the set-up stage to the walker
    typedef struct packed {
        logic               empty;
        logic signed [13:0] x0;
        logic signed [13:0] y0;
        logic        [11:0] cx0;
        logic        [11:0] cy0;
        logic        [11:0] cx1;
        logic        [11:0] cy1;
        logic        [14:0] dx;
        logic        [14:0] dy;
    } geom_t;

endpackage
`default_nettype wire

FILE: src/sabw_geom.sv
// rectangle set-up: serial scaling of the rectangle edges, clipping and empty test
`default_nettype none
module sabw_geom
    import sabw_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [11:0] dest_x,
    input  wire logic signed [11:0] dest_y,
    input  wire logic signed [12:0] dest_width,
    input  wire logic signed [12:0] dest_height,
    input  wire logic        [10:0] source_width,
    input  wire logic        [10:0] source_height,
    output logic                    busy,
    output geom_t                   geom
);

    logic signed [13:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [13:0] cx0, cy0, cx1, cy1;
    logic signed [13:0] edge_val;
    logic signed [13:0] scaled;
    logic        [13:0] mag;
    logic               neg;
    logic               empty;
    logic [NUM_W-1:0]   numer, quot;
    logic [DEN_W-1:0]   denom;
    logic               div_done;
    logic [1:0]         idx_reg;
    logic               busy_reg;
    logic               launch_reg;

    // edge selection, magnitude and scaling for a division truncating toward zero
    always_comb begin
        case (idx_reg)
            2'd0:    edge_val = 14'(dest_x);
            2'd1:    edge_val = 14'(dest_y);
            2'd2:    edge_val = 14'(dest_x) + 14'(dest_width);
            default: edge_val = 14'(dest_y) + 14'(dest_height);
        endcase
        neg = edge_val[13];
        mag = neg ? 14'(-edge_val) : edge_val;
        if (idx_reg[0]) begin
            numer = NUM_W'(mag * SCREEN_H);
            denom = DEN_W'(FIELD_HEIGHT);
        end else begin
            numer = NUM_W'(mag * SCREEN_W);
            denom = DEN_W'(FIELD_WIDTH);
        end
        scaled = 14'(quot);
        if (neg) begin
            scaled = -scaled;
        end
    end

    sabw_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(launch_reg), .numer(numer),
        .denom(denom), .done(div_done), .quot(quot)
    );

    // edge sequencer, restarted by every configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b1;
            launch_reg <= 1'b1;
            idx_reg    <= '0;
        end else begin
            launch_reg <= 1'b0;
            if (start) begin
                busy_reg   <= 1'b1;
                launch_reg <= 1'b1;
                idx_reg    <= '0;
            end else if (busy_reg && !launch_reg && div_done) begin
                unique case (idx_reg)
                    2'd0: x0_reg <= scaled;
                    2'd1: y0_reg <= scaled;
                    2'd2: x1_reg <= scaled;
                    2'd3: y1_reg <= scaled;
                endcase
                if (idx_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end else begin
                    idx_reg    <= idx_reg + 1'b1;
                    launch_reg <= 1'b1;
                end
            end
        end
    end

    // clipping and empty test on the scaled edges
    always_comb begin
        cx0 = (x0_reg < 0) ? 14'sd0 : x0_reg;
        cy0 = (y0_reg < 0) ? 14'sd0 : y0_reg;
        cx1 = (x1_reg > 14'(SCREEN_W)) ? 14'(SCREEN_W) : x1_reg;
        cy1 = (y1_reg > 14'(SCREEN_H)) ? 14'(SCREEN_H) : y1_reg;
        empty = (source_width == '0) || (source_height == '0) ||
                (dest_width <= 0) || (dest_height <= 0) ||
                (x1_reg <= x0_reg) || (y1_reg <= y0_reg) || (cx0 >= cx1) || (cy0 >= cy1);
        geom.empty = empty;
        geom.x0    = x0_reg;
        geom.y0    = y0_reg;
        geom.cx0   = cx0[11:0];
        geom.cy0   = cy0[11:0];
        geom.cx1   = cx1[11:0];
        geom.cy1   = cy1[11:0];
        geom.dx    = 15'(x1_reg - x0_reg);
        geom.dy    = 15'(y1_reg - y0_reg);
    end

    assign busy = busy_reg;

endmodule
`default_nettype wire

FILE: src/sabw_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module sabw_div
    import sabw_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numer,
    input  wire logic [DEN_W-1:0] denom,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;

    // shift one numerator bit into the remainder and try a subtract
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (start) begin
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quot = q_next;

endmodule
`default_nettype wire

FILE: src/sabw_blend.sv
// per-channel blend: product sums computed, then divided by 255 bit-serially
`default_nettype none
module sabw_blend
    import sabw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] texel,
    input  wire logic [23:0] pixel,
    output logic             done,
    output logic      [23:0] color
);

    logic [2:0][15:0] sum;
    logic [2:0][15:0] n_reg, n_next;
    logic [2:0][8:0]  r_reg, r_next;
    logic [2:0][8:0]  trial;
    logic [7:0]       a;
    logic [3:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    assign a = texel[31:24];

    // weighted channel sums of the incoming transaction, red in lane 2
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = 16'(texel[8*c +: 8] * a) + 16'(pixel[8*c +: 8] * (8'd255 - a));
        end
    end

    // sixteen restoring steps, all three channels side by side
    always_comb begin
        n_next    = n_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        for (int c = 0; c < 3; c++) begin
            trial[c] = {r_reg[c][7:0], n_reg[c][15]};
        end
        if (start) begin
            n_next    = sum;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int c = 0; c < 3; c++) begin
                if (trial[c] >= 9'd255) begin
                    r_next[c] = trial[c] - 9'd255;
                    n_next[c] = {n_reg[c][14:0], 1'b1};
                end else begin
                    r_next[c] = trial[c];
                    n_next[c] = {n_reg[c][14:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        n_reg <= n_next;
        r_reg <= r_next;
    end

    assign done  = busy_reg && (cnt_reg == 4'd15);
    assign color = {n_next[2][7:0], n_next[1][7:0], n_next[0][7:0]};

endmodule
`default_nettype wire

FILE: src/scaled_alpha_blit_walker.sv
// top level: configuration registers, walk sequencer and result register
//
// Scaled alpha blit walker. Configuration writes (cfg_we, cfg_addr, cfg_data)
// set the destination rectangle, source size and blend mode; each write
// restarts the walk at the first clipped pixel. After a write the four rectangle
// edges are scaled one after another in a radix-2 divider; the input is held
// off until the walk has restarted.
// The s_ channel carries one transaction per pixel: the source texel at the
// current mapped position and the destination pixel at the current screen
// position. The m_ channel returns one transaction per input: write position,
// write enable and colour, the next fetch positions and a last-pixel flag
// on m_tlast.
// The two texel-coordinate divisions run in parallel in radix-2 dividers
// of 26 steps; a blend divides its three channels by 255 side by side in
// 16 steps.
// The input is taken only when the block is free; a finished result waits
// in the output register while the receiver stalls, and the next item is
// not taken until it leaves.
// Reset clears the registers (empty rectangle) and the handshakes, then the
// geometry is set up as after a write.
`default_nettype none
module scaled_alpha_blit_walker
    import sabw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // source_texel, dest_pixel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // write_col, write_row, write_enable,
                                        // out_color, fetch_col, fetch_row,
                                        // texel_col, texel_row, zero fill
    output logic             m_tlast    // final_pixel
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

    logic signed [11:0] dx_reg, dy_reg;
    logic signed [12:0] dw_reg, dh_reg;
    logic        [10:0] sw_reg, sh_reg;
    logic               be_reg;
    logic               rst_walk_reg;
    logic               geom_busy;
    geom_t              g;
    state_t             state_reg;
    logic        [11:0] col_reg, row_reg, ncol_reg, nrow_reg;
    logic        [11:0] ncol, nrow;
    logic               fin, fin_reg;
    logic        [31:0] tex_reg;
    logic        [23:0] pix_reg;
    logic               write_en, cdone_reg, dvx_ok, dvy_ok, dvx_reg, dvy_reg;
    logic [NUM_W-1:0]   qx, qy;
    logic [9:0]         tc_reg, tr_reg;
    logic               bstart, bdone, dstart;
    logic        [23:0] bcolor, col_out_reg;
    logic               empty_out_reg;
    logic [NUM_W-1:0]   numx, numy;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg <= '0; dy_reg <= '0; dw_reg <= '0; dh_reg <= '0;
            sw_reg <= '0; sh_reg <= '0; be_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEST_X: dx_reg <= cfg_data[11:0];
                REG_DEST_Y: dy_reg <= cfg_data[11:0];
                REG_DEST_W: dw_reg <= cfg_data;
                REG_DEST_H: dh_reg <= cfg_data;
                REG_SRC_W:  sw_reg <= cfg_data[10:0];
                REG_SRC_H:  sh_reg <= cfg_data[10:0];
                REG_BLEND:  be_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sabw_geom u_geom (
        .aclk(aclk), .aresetn(aresetn), .start(cfg_we), .dest_x(dx_reg),
        .dest_y(dy_reg), .dest_width(dw_reg), .dest_height(dh_reg),
        .source_width(sw_reg), .source_height(sh_reg), .busy(geom_busy),
        .geom(g)
    );

    // next walk position and texel-coordinate numerators
    always_comb begin
        ncol = col_reg + 1'b1;
        nrow = row_reg;
        fin  = 1'b0;
        if (ncol >= g.cx1) begin
            ncol = g.cx0;
            nrow = row_reg + 1'b1;
            if (nrow >= g.cy1) begin
                nrow = g.cy0;
                fin  = 1'b1;
            end
        end
        numx = NUM_W'(14'($signed({2'b00, ncol_reg}) - g.x0) * sw_reg);
        numy = NUM_W'(14'($signed({2'b00, nrow_reg}) - g.y0) * sh_reg);
    end

    assign s_tready = (state_reg == ST_IDLE) && !rst_walk_reg && !cfg_we;
    assign bstart   = s_tready && s_tvalid;

    sabw_div u_divx (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .numer(numx),
        .denom(g.dx), .done(dvx_ok), .quot(qx)
    );
    sabw_div u_divy (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .numer(numy),
        .denom(g.dy), .done(dvy_ok), .quot(qy)
    );
    sabw_blend u_blend (
        .aclk(aclk), .aresetn(aresetn), .start(bstart), .texel(s_tdata[31:0]),
        .pixel(s_tdata[55:32]), .done(bdone), .color(bcolor)
    );

    logic dstart_reg;
    assign dstart = dstart_reg;

    // sequencer and registered results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rst_walk_reg <= 1'b1;
            col_reg      <= '0;
            row_reg      <= '0;
            m_tvalid     <= 1'b0;
            dstart_reg   <= 1'b0;
            dvx_reg      <= 1'b0;
            dvy_reg      <= 1'b0;
            cdone_reg    <= 1'b0;
        end else begin
            dstart_reg <= 1'b0;
            if (cfg_we) begin
                rst_walk_reg <= 1'b1;
            end else if (rst_walk_reg && !geom_busy) begin
                rst_walk_reg <= 1'b0;
                col_reg      <= g.empty ? 12'd0 : g.cx0;
                row_reg      <= g.empty ? 12'd0 : g.cy0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (bstart) begin
                        state_reg  <= ST_RUN;
                        dstart_reg <= 1'b1;
                        dvx_reg    <= 1'b0;
                        dvy_reg    <= 1'b0;
                        cdone_reg  <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (dvx_ok) dvx_reg <= 1'b1;
                    if (dvy_ok) dvy_reg <= 1'b1;
                    if (bdone) cdone_reg <= 1'b1;
                    if ((dvx_reg || dvx_ok) && (dvy_reg || dvy_ok) &&
                        (cdone_reg || bdone || !(be_reg && tex_reg[31:24] != ALPHA_CLEAR
                         && tex_reg[31:24] != ALPHA_OPAQUE))) begin
                        state_reg <= ST_OUT;
                        m_tvalid  <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        m_tvalid  <= 1'b0;
                        state_reg <= ST_IDLE;
                        if (!empty_out_reg) begin
                            col_reg <= ncol_reg;
                            row_reg <= nrow_reg;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
        if (bstart) begin
            tex_reg       <= s_tdata[31:0];
            pix_reg       <= s_tdata[55:32];
            ncol_reg      <= ncol;
            nrow_reg      <= nrow;
            fin_reg       <= fin;
            empty_out_reg <= g.empty;
        end
        if (dvx_ok) tc_reg <= qx[9:0];
        if (dvy_ok) tr_reg <= qy[9:0];
        if (bdone)  col_out_reg <= bcolor;
    end

    // colour and write-enable selection
    logic [23:0] color;
    always_comb begin
        write_en = 1'b1;
        color    = tex_reg[23:0];
        if (be_reg) begin
            if (tex_reg[31:24] == ALPHA_CLEAR) begin
                write_en = 1'b0;
                color    = pix_reg;
            end else if (tex_reg[31:24] != ALPHA_OPAQUE) begin
                color = col_out_reg;
            end
        end
    end

    always_comb begin
        if (empty_out_reg) begin
            m_tdata = '0;
            m_tlast = 1'b1;
        end else begin
            m_tdata = {1'b0, tr_reg, tc_reg, nrow_reg[9:0], ncol_reg[10:0], color,
                       write_en, row_reg[9:0], col_reg[10:0]};
            m_tlast = fin_reg;
        end
    end

endmodule
`default_nettype wire
